[hw/rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cia_pkg.sv]
package cia_pkg;

	localparam int DATA_W = 32;
	localparam int STEP_W = $clog2(DATA_W);

	// action codes
	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_SUB   = 3'd1;
	localparam logic [2:0] ACT_MUL   = 3'd2;
	localparam logic [2:0] ACT_POW   = 3'd3;
	localparam logic [2:0] ACT_DIV   = 3'd4;
	localparam logic [2:0] ACT_MOD   = 3'd5;
	localparam logic [2:0] ACT_CLEAR = 3'd6;
	localparam logic [2:0] ACT_NOP   = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_ADD   = 3'd1;
	localparam logic [2:0] ERR_SUB   = 3'd2;
	localparam logic [2:0] ERR_MUL   = 3'd3;
	localparam logic [2:0] ERR_POW   = 3'd4;
	localparam logic [2:0] ERR_DIVZ  = 3'd5;
	localparam logic [2:0] ERR_MODZ  = 3'd6;
	localparam logic [2:0] ERR_QUOT  = 3'd7;

	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0]               action;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} cia_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [2:0]               error_code;
	} cia_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MCHK,
		ST_PMUL,
		ST_PCHK,
		ST_DIV,
		ST_DFIN,
		ST_DONE
	} cia_state_t;

	typedef enum logic [1:0] {
		UOP_NONE,
		UOP_MUL,
		UOP_DLOAD,
		UOP_DSTEP
	} cia_uop_t;

	typedef struct packed {
		cia_uop_t          op;
		logic [DATA_W-1:0] opa;
		logic [DATA_W-1:0] opb;
	} cia_ucmd_t;

	typedef struct packed {
		logic [2*DATA_W-1:0] prod;
		logic [DATA_W-1:0]   quo;
		logic [DATA_W-1:0]   rem;
	} cia_ures_t;

	// two's complement negate of a magnitude
	function automatic logic [DATA_W-1:0] neg_val(input logic [DATA_W-1:0] x);
		return ~x + {{(DATA_W-1){1'b0}}, 1'b1};
	endfunction

	// magnitude of a signed word, the minimum maps to its exact unsigned magnitude
	function automatic logic [DATA_W-1:0] mag_val(input logic [DATA_W-1:0] x);
		return x[DATA_W-1] ? neg_val(x) : x;
	endfunction

	// unsigned product fits the signed range for the given sign
	function automatic logic prod_fits(input logic [2*DATA_W-1:0] p, input logic neg);
		logic hi_zero;
		hi_zero = (p[2*DATA_W-1:DATA_W] == '0);
		return hi_zero && (neg ? (p[DATA_W-1:0] <= VAL_MIN) : !p[DATA_W-1]);
	endfunction

endpackage

[hw/rtl/cia_unit.sv]
module cia_unit (
	input  logic               clk,
	input  cia_pkg::cia_ucmd_t ucmd,
	output cia_pkg::cia_ures_t ures
);
	import cia_pkg::*;

	logic [2*DATA_W-1:0] prod_q;
	logic [DATA_W-1:0]   quo_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   dvs_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] trial;

	// restoring divide: shift in one dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[DATA_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	// shared multiply and divide-step registers
	always_ff @(posedge clk) begin
		case (ucmd.op)
			UOP_MUL: begin
				prod_q <= {{DATA_W{1'b0}}, ucmd.opa} * {{DATA_W{1'b0}}, ucmd.opb};
			end
			UOP_DLOAD: begin
				quo_q <= ucmd.opa;
				dvs_q <= ucmd.opb;
				rem_q <= '0;
			end
			UOP_DSTEP: begin
				if (!trial[DATA_W+1]) begin
					rem_q <= trial[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign ures.prod = prod_q;
	assign ures.quo  = quo_q;
	assign ures.rem  = rem_q;

endmodule

[hw/rtl/checked_integer_alu_core.sv]
// add, sub, clear, blocked commands, trivial powers and divides by zero or overflow go
// straight to ST_DONE, mul via ST_MCHK, div and mod via ST_DIV and ST_DFIN, power via
// ST_PMUL and ST_PCHK per multiply step; one command at a time, paced by the shared
// multiplier and the one-bit-per-cycle restoring divider in cia_unit
// arst_n clears the sequencer, the response valid flag and the sticky error code
module checked_integer_alu_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cia_pkg::cia_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cia_pkg::cia_rsp_t rsp
);
	import cia_pkg::*;

	cia_state_t state_q, state_d;
	cia_ucmd_t  ucmd;
	cia_ures_t  ures;

	logic [2:0]        sticky_q;
	logic [2:0]        act_q;
	logic              sa_q, sb_q, neg_q;
	logic [DATA_W-1:0] ma_q, acc_q, val_q;
	logic [2:0]        code_q;
	logic [DATA_W-2:0] cnt_q;
	logic [STEP_W-1:0] stp_q;
	cia_rsp_t          rsp_q;
	logic              rsp_valid_q;

	logic              accept, rsp_free;
	logic [2:0]        act;
	logic [DATA_W-1:0] a_u, b_u, mag_a, mag_b;
	logic              blocked, go_mul, go_pow, go_div;
	logic              b_le1, pow_easy, div_err;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] imm_val, easy_val;
	logic [2:0]        imm_code;
	logic              mul_neg, mul_ok, pow_neg, pow_ok;
	logic [DATA_W-1:0] prod_lo, quo_s, rem_s;

	assign accept    = cmd_valid && cmd_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE);

	// command decode
	always_comb begin
		act     = cmd.action;
		a_u     = cmd.operand_a;
		b_u     = cmd.operand_b;
		mag_a   = mag_val(a_u);
		mag_b   = mag_val(b_u);
		blocked = (act == ACT_NOP) || (act == ACT_CLEAR) || (sticky_q != ERR_NONE);
		b_le1   = b_u[DATA_W-1] || (b_u[DATA_W-1:1] == '0);
		pow_easy = b_le1 || (mag_a[DATA_W-1:1] == '0);
		div_err = (b_u == '0)
			|| ((act == ACT_DIV) && (a_u == VAL_MIN) && (b_u == '1));
		go_mul  = !blocked && (act == ACT_MUL);
		go_pow  = !blocked && (act == ACT_POW) && !pow_easy;
		go_div  = !blocked && ((act == ACT_DIV) || (act == ACT_MOD)) && !div_err;
	end

	// power with a trivial exponent or base
	always_comb begin
		if (b_u == '0) begin
			easy_val = {{(DATA_W-1){1'b0}}, 1'b1};
		end else if (b_le1) begin
			easy_val = a_u;
		end else if (a_u[DATA_W-1]) begin
			easy_val = b_u[0] ? '1 : {{(DATA_W-1){1'b0}}, 1'b1};
		end else begin
			easy_val = a_u;
		end
	end

	// results settled in the transfer cycle
	always_comb begin
		imm_val  = '0;
		imm_code = sticky_q;
		sum      = '0;
		if (!blocked) begin
			case (act)
				ACT_ADD, ACT_SUB: begin
					if (act == ACT_ADD) begin
						sum = {a_u[DATA_W-1], a_u} + {b_u[DATA_W-1], b_u};
					end else begin
						sum = {a_u[DATA_W-1], a_u} - {b_u[DATA_W-1], b_u};
					end
					if (sum[DATA_W] != sum[DATA_W-1]) begin
						imm_code = (act == ACT_ADD) ? ERR_ADD : ERR_SUB;
					end else begin
						imm_val = sum[DATA_W-1:0];
					end
				end
				ACT_POW: begin
					imm_val = easy_val;
				end
				ACT_DIV: begin
					if (div_err) begin
						imm_code = (b_u == '0) ? ERR_DIVZ : ERR_QUOT;
					end
				end
				ACT_MOD: begin
					if (div_err) begin
						imm_code = ERR_MODZ;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// checks on the shared unit results
	always_comb begin
		prod_lo = ures.prod[DATA_W-1:0];
		mul_neg = sa_q ^ sb_q;
		mul_ok  = prod_fits(ures.prod, mul_neg);
		pow_neg = neg_q ^ sa_q;
		pow_ok  = prod_fits(ures.prod, pow_neg);
		quo_s   = (sa_q ^ sb_q) ? neg_val(ures.quo) : ures.quo;
		rem_s   = sa_q ? neg_val(ures.rem) : ures.rem;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (go_mul) begin
						state_d = ST_MCHK;
					end else if (go_pow) begin
						state_d = ST_PMUL;
					end else if (go_div) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MCHK: state_d = ST_DONE;
			ST_PMUL: state_d = ST_PCHK;
			ST_PCHK: begin
				if (!pow_ok || (cnt_q == {{(DATA_W-2){1'b0}}, 1'b1})) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_PMUL;
				end
			end
			ST_DIV: begin
				if (stp_q == '0) begin
					state_d = ST_DFIN;
				end
			end
			ST_DFIN: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared unit command
	always_comb begin
		ucmd.op  = UOP_NONE;
		ucmd.opa = acc_q;
		ucmd.opb = ma_q;
		unique case (state_q)
			ST_IDLE: begin
				ucmd.opa = mag_a;
				ucmd.opb = mag_b;
				if (accept && go_mul) begin
					ucmd.op = UOP_MUL;
				end else if (accept && go_div) begin
					ucmd.op = UOP_DLOAD;
				end
			end
			ST_PMUL: ucmd.op = UOP_MUL;
			ST_DIV:  ucmd.op = UOP_DSTEP;
			default: ucmd.op = UOP_NONE;
		endcase
	end

	cia_unit u_unit (
		.clk  (clk),
		.ucmd (ucmd),
		.ures (ures)
	);

	// control state and sticky code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sticky_q    <= ERR_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sticky_q <= (act == ACT_CLEAR) ? ERR_NONE : imm_code;
					end
				end
				ST_MCHK: begin
					if (!mul_ok) begin
						sticky_q <= ERR_MUL;
					end
				end
				ST_PCHK: begin
					if (!pow_ok) begin
						sticky_q <= ERR_POW;
					end
				end
				default: begin
				end
			endcase
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_q  <= act;
					sa_q   <= a_u[DATA_W-1];
					sb_q   <= b_u[DATA_W-1];
					ma_q   <= mag_a;
					acc_q  <= mag_a;
					neg_q  <= a_u[DATA_W-1];
					cnt_q  <= b_u[DATA_W-2:0] - {{(DATA_W-2){1'b0}}, 1'b1};
					stp_q  <= STEP_W'(DATA_W - 1);
					val_q  <= imm_val;
					code_q <= imm_code;
				end
			end
			ST_MCHK: begin
				val_q  <= !mul_ok ? '0 : (mul_neg ? neg_val(prod_lo) : prod_lo);
				code_q <= mul_ok ? ERR_NONE : ERR_MUL;
			end
			ST_PCHK: begin
				acc_q  <= prod_lo;
				neg_q  <= pow_neg;
				cnt_q  <= cnt_q - {{(DATA_W-2){1'b0}}, 1'b1};
				val_q  <= !pow_ok ? '0 : (pow_neg ? neg_val(prod_lo) : prod_lo);
				code_q <= pow_ok ? ERR_NONE : ERR_POW;
			end
			ST_DIV: begin
				stp_q <= stp_q - {{(STEP_W-1){1'b0}}, 1'b1};
			end
			ST_DFIN: begin
				val_q  <= (act_q == ACT_DIV) ? quo_s : rem_s;
				code_q <= ERR_NONE;
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.value      <= val_q;
					rsp_q.error_code <= code_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/cia_checker.sv]
`include "assert_macros.svh"

module cia_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input cia_pkg::cia_cmd_t cmd,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input cia_pkg::cia_rsp_t rsp
);
	import cia_pkg::*;

	// response stays offered until its transfer
	`CIA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped before transfer")

	// stalled response payload holds
	`CIA_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp), "response payload changed while stalled")

	// one command in flight: ready falls after a command transfer
	`CIA_ASSERT_NEXT(a_one_cmd, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "second command taken while busy")

	// a pending or raised error always comes with a zero value
	`CIA_ASSERT_NOW(a_err_zero, clk, arst_n, rsp_valid && (rsp.error_code != ERR_NONE), rsp.value == '0, "nonzero value with an error code")

endmodule

bind checked_integer_alu_core cia_checker u_cia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
